FILE: hdl/gpm_pkg.sv
// gpm_pkg: shared types and constants of the glob pattern matcher
// used by the interfaces, the cell row and the top level; no dependencies
`timescale 1ns / 1ps

package gpm_pkg;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int MASK_W = 32;
    localparam int LEN_W  = 6;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [LEN_W-1:0]  len_t;

    localparam cmd_t CMD_LOAD_CLASS = 2'd0;
    localparam cmd_t CMD_LOAD_STAR  = 2'd1;
    localparam cmd_t CMD_TEXT       = 2'd2;
    localparam cmd_t CMD_EMPTY      = 2'd3;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t OP_HOLD  = 2'd0;
    localparam cell_op_t OP_START = 2'd1;
    localparam cell_op_t OP_CLOSE = 2'd2;
    localparam cell_op_t OP_STEP  = 2'd3;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

FILE: hdl/gpm_if.sv
// gpm_if: valid/ready channels of the glob pattern matcher
// depends on gpm_pkg for the payload types
`timescale 1ns / 1ps

interface gpm_in_if;
    logic             valid;
    logic             ready;
    gpm_pkg::cmd_t    command;
    gpm_pkg::char_t   char_value;
    gpm_pkg::mask_t   node_mask;
    logic             last_char;

    modport source (output valid, command, char_value, node_mask, last_char, input ready);
    modport sink   (input valid, command, char_value, node_mask, last_char, output ready);
endinterface

interface gpm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

interface gpm_cfg_if;
    logic           valid;
    logic           ready;
    gpm_pkg::len_t  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: hdl/gpm_ram.sv
// gpm_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/gpm_cell.sv
// gpm_cell: one pattern position of the automaton row
// holds one active bit and passes star and character carries to its right neighbor
// depends on gpm_pkg
`timescale 1ns / 1ps

module gpm_cell #(
    parameter bit START = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gpm_pkg::cell_ctrl_t ctrl,
    input  logic                left_star_carry,
    input  logic                left_char_carry,
    input  logic                star_bit,
    input  logic                class_bit,
    input  logic                en,
    output logic                active,
    output logic                star_carry,
    output logic                char_carry,
    output logic                changed
);

    logic active_reg;
    logic active_next;

    always_comb
    begin
        unique case (ctrl.op)
            gpm_pkg::OP_START: active_next = START;
            // star skip: a star reached from the left may match nothing
            gpm_pkg::OP_CLOSE: active_next = active_reg | left_star_carry;
            // consume one character: advance, or stay on an accepting star
            gpm_pkg::OP_STEP:  active_next = left_char_carry | (char_carry & star_bit);
            default:           active_next = active_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= START;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active     = active_reg;
    assign star_carry = active_reg & star_bit & en;
    assign char_carry = active_reg & class_bit & en;
    // star closure still has to reach this cell; independent of the current op
    assign changed    = left_star_carry & ~active_reg;

endmodule

FILE: hdl/glob_pattern_matcher.sv
// glob_pattern_matcher: top level, sequencer, class table ram and the cell row
// depends on gpm_pkg, gpm_if, gpm_ram and gpm_cell
//
//   channel   dir   payload                                      transfer
//   cfg_ch    in    data = pattern_length                        valid & ready
//   in_ch     in    command, char_value, node_mask, last_char    valid & ready
//   out_ch    out   matched                                      valid & ready
//
// load commands leave the sequencer idle and in_ch ready; a text character
// runs a star closure (S_CLOSE1) until no cell changes, then a step (S_STEP)
// (star closure moves one position per cycle along the cell row); the last
// character adds a second closure (S_CLOSE2) before the result; an empty-string
// request restarts the row and runs S_CLOSE2; reset clears the star mask and
// the length and returns the active set to position 0; the class table holds
// garbage until written; in_ch waits while a result cannot be posted
`timescale 1ns / 1ps

module glob_pattern_matcher #(
    parameter int MAX_POSITIONS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gpm_cfg_if.sink    cfg_ch,
    gpm_in_if.sink     in_ch,
    gpm_out_if.source  out_ch
);

    localparam int EL_W = $clog2(MAX_POSITIONS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CLOSE1 = 2'd1;
    localparam logic [1:0] S_STEP   = 2'd2;
    localparam logic [1:0] S_CLOSE2 = 2'd3;

    logic [1:0]          state_reg, state_next;
    gpm_pkg::len_t       len_reg;
    gpm_pkg::mask_t      star_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic                matched_reg;

    gpm_pkg::cell_ctrl_t ctrl;
    gpm_pkg::mask_t      class_word;
    logic                in_xfer;
    logic                out_free;
    logic                any_change;
    logic                post_result;
    logic [6:0]          len_sat;
    logic [EL_W-1:0]     eff_len;

    logic [MAX_POSITIONS:0] active_vec;
    logic [MAX_POSITIONS:0] star_carry_vec;
    logic [MAX_POSITIONS:0] char_carry_vec;
    logic [MAX_POSITIONS:0] change_vec;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_xfer      = in_ch.valid & in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.matched = matched_reg;

    assign len_sat = (7'(len_reg) > 7'(MAX_POSITIONS)) ? 7'(MAX_POSITIONS) : 7'(len_reg);
    assign eff_len = len_sat[EL_W-1:0];

    assign any_change  = |change_vec;
    assign post_result = (state_reg == S_CLOSE2) && !any_change && out_free;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = gpm_pkg::OP_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_ch.command == gpm_pkg::CMD_TEXT)
                    begin
                        state_next = S_CLOSE1;
                    end
                    else if (in_ch.command == gpm_pkg::CMD_EMPTY)
                    begin
                        ctrl.op    = gpm_pkg::OP_START;
                        state_next = S_CLOSE2;
                    end
                end
            end
            S_CLOSE1:
            begin
                ctrl.op = gpm_pkg::OP_CLOSE;
                if (!any_change)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                ctrl.op    = gpm_pkg::OP_STEP;
                state_next = last_reg ? S_CLOSE2 : S_IDLE;
            end
            S_CLOSE2:
            begin
                if (post_result)
                begin
                    ctrl.op    = gpm_pkg::OP_START;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.op = gpm_pkg::OP_CLOSE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            star_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                len_reg <= cfg_ch.data;
            end
            if (in_xfer && in_ch.command == gpm_pkg::CMD_LOAD_STAR)
            begin
                star_reg <= in_ch.node_mask;
            end
            if (in_xfer)
            begin
                last_reg <= in_ch.last_char;
            end
            if (post_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_result)
        begin
            matched_reg <= active_vec[eff_len];
        end
    end

    // class table: one column word per character
    gpm_ram #(
        .WIDTH (gpm_pkg::MASK_W),
        .DEPTH (1 << gpm_pkg::CHAR_W)
    ) u_class_ram (
        .clk     (clk),
        .wr_en   (in_xfer && in_ch.command == gpm_pkg::CMD_LOAD_CLASS),
        .wr_addr (in_ch.char_value),
        .wr_data (in_ch.node_mask),
        .rd_en   (in_xfer && in_ch.command == gpm_pkg::CMD_TEXT),
        .rd_addr (in_ch.char_value),
        .rd_data (class_word)
    );

    // cell row: position i plus the final "whole pattern matched" position
    for (genvar i = 0; i <= MAX_POSITIONS; i++)
    begin : g_cell
        logic left_star;
        logic left_char;
        logic star_bit;
        logic class_bit;
        logic en;

        if (i == 0)
        begin : g_first
            assign left_star = 1'b0;
            assign left_char = 1'b0;
        end
        else
        begin : g_inner
            assign left_star = star_carry_vec[i-1];
            assign left_char = char_carry_vec[i-1];
        end

        if (i < MAX_POSITIONS && i < gpm_pkg::MASK_W)
        begin : g_bits
            assign star_bit  = star_reg[i];
            assign class_bit = class_word[i];
        end
        else
        begin : g_nobits
            assign star_bit  = 1'b0;
            assign class_bit = 1'b0;
        end

        assign en = (7'(i) < len_sat);

        gpm_cell #(
            .START (i == 0)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .left_star_carry (left_star),
            .left_char_carry (left_char),
            .star_bit        (star_bit),
            .class_bit       (class_bit),
            .en              (en),
            .active          (active_vec[i]),
            .star_carry      (star_carry_vec[i]),
            .char_carry      (char_carry_vec[i]),
            .changed         (change_vec[i])
        );
    end

endmodule
